FILE: rtl/core/table_hash_probe_generator_top_assert.svh
// Assertion macros used by the probe generator back end.
`ifndef TABLE_HASH_PROBE_GENERATOR_TOP_ASSERT_SVH
`define TABLE_HASH_PROBE_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define THPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/thpg_pkg.sv
package thpg_pkg;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       key_last;
   } req_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [17:0] probe_index;
      logic        probe_valid;
      logic        probe_last;
   } rsp_type;

   typedef struct packed {
      logic [16:0] low;
      logic [16:0] high;
   } bounds_type;

   typedef struct packed {
      logic        push;
      logic [31:0] hash;
   } hash_push_type;

   typedef struct packed {
      logic        empty;
      logic [31:0] hash;
   } hash_head_type;

   localparam logic [1:0]  CSR_LOW_BOUND    = 2'd0;
   localparam logic [1:0]  CSR_HIGH_BOUND   = 2'd1;
   localparam logic [16:0] MASK_LIMIT       = 17'h1ffff;
   localparam logic [16:0] LOW_BOUND_RESET  = 17'h080e0;
   localparam logic [16:0] HIGH_BOUND_RESET = 17'h1fd00;

   localparam logic [31:0] MIX_TABLE [64] = '{
      32'h3100d2bf, 32'h3118e3de, 32'h34ab1372, 32'h2807a847,
      32'h1633f566, 32'h2143b359, 32'h26d56488, 32'h3b9e6f59,
      32'h37755656, 32'h3089ca7b, 32'h18e92d85, 32'h0cd0e9d8,
      32'h1a9e3b54, 32'h3eaa902f, 32'h0d9bfaae, 32'h2f32b45b,
      32'h31ed6102, 32'h3d3c8398, 32'h146660e3, 32'h0f8d4b76,
      32'h02c77a5f, 32'h146c8799, 32'h1c47f51f, 32'h249f8f36,
      32'h24772043, 32'h1fbc1e4d, 32'h1e86b3fa, 32'h37df36a6,
      32'h16ed30e4, 32'h02c3148e, 32'h216e5929, 32'h0636b34e,
      32'h317f9f56, 32'h15f09d70, 32'h131026fb, 32'h38c784b1,
      32'h29ac3305, 32'h2b485dc5, 32'h3c049ddc, 32'h35a9fbcd,
      32'h31d5373b, 32'h2b246799, 32'h0a2923d3, 32'h08a96e9d,
      32'h30031a9f, 32'h08f525b5, 32'h33611c06, 32'h2409db98,
      32'h0ca4feb2, 32'h1000b71e, 32'h30566e32, 32'h39447d31,
      32'h194e3752, 32'h08233a95, 32'h0f38fe36, 32'h29c7cd57,
      32'h0f7b3a39, 32'h328e8a16, 32'h1e7d1388, 32'h0fba78f5,
      32'h274c7e7c, 32'h1e8be65c, 32'h2fa0b0bb, 32'h1eb6c371
   };

   // Adding 4*(15 - nibble) + 1 equals adding {~nibble, 2'b01} modulo 64.
   function automatic logic [5:0] mix_step(input logic [5:0] idx, input logic [3:0] nib);
      mix_step = idx + {~nib, 2'b01};
   endfunction

endpackage

FILE: rtl/core/thpg_front.sv
module thpg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  thpg_pkg::req_type      req_data,
   output thpg_pkg::hash_push_type hash_out
);
   import thpg_pkg::*;

   logic [5:0]  mix_index_ff, mix_index_in;
   logic [31:0] hash_sum_ff, hash_sum_in;
   logic [5:0]  idx_lo, idx_hi;
   logic [31:0] sum_lo, sum_hi;

   always_comb begin
      idx_lo = mix_step(mix_index_ff, req_data.key_byte[3:0]);
      sum_lo = hash_sum_ff + MIX_TABLE[idx_lo];
      idx_hi = mix_step(idx_lo, req_data.key_byte[7:4]);
      sum_hi = sum_lo + MIX_TABLE[idx_hi];

      mix_index_in = mix_index_ff;
      hash_sum_in  = hash_sum_ff;
      if (accept) begin
         // The last byte pushes the hash into the hash queue and starts a new key.
         if (req_data.key_last) begin
            mix_index_in = '0;
            hash_sum_in  = '0;
         end else begin
            mix_index_in = idx_hi;
            hash_sum_in  = sum_hi;
         end
      end

      hash_out.push = accept & req_data.key_last;
      hash_out.hash = sum_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_index_ff <= '0;
         hash_sum_ff  <= '0;
      end else begin
         mix_index_ff <= mix_index_in;
         hash_sum_ff  <= hash_sum_in;
      end
   end

endmodule

FILE: rtl/core/thpg_hash_queue.sv
module thpg_hash_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  thpg_pkg::hash_push_type push_in,
   output logic                    full,
   input  logic                    pop,
   output thpg_pkg::hash_head_type head
);
   import thpg_pkg::*;

   logic [31:0] mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   always_comb begin
      full    = (count_ff == 2'd2);
      do_push = push_in.push & ~full;
      do_pop  = pop & (count_ff != 2'd0);

      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 2'd1;
      end

      head.empty = (count_ff == 2'd0);
      head.hash  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/thpg_back.sv
`include "table_hash_probe_generator_top_assert.svh"

module thpg_back (
   input  logic                    clock,
   input  logic                    reset,
   input  thpg_pkg::hash_head_type head,
   input  thpg_pkg::bounds_type    bounds,
   output logic                    hash_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output thpg_pkg::rsp_type       rsp_data
);
   import thpg_pkg::*;

   logic [16:0] mask_ff, mask_in;
   rsp_type     oq_mem_ff [2];
   logic        oq_wr_ff, oq_wr_in;
   logic        oq_rd_ff, oq_rd_in;
   logic [1:0]  oq_count_ff, oq_count_in;

   logic [17:0] probe;
   logic        qualifies, at_limit, step, emit, walk_done, oq_pop;
   rsp_type     word;

   always_comb begin
      probe     = {1'b0, head.hash[16:0] & mask_ff} + {1'b0, mask_ff};
      qualifies = (probe >= {1'b0, bounds.low});
      at_limit  = (mask_ff == MASK_LIMIT);
      step      = ~head.empty & (oq_count_ff != 2'd2);

      // At the mask limit a word always goes out, as an invalid marker if
      // nothing qualified on the whole walk.
      emit      = step & (qualifies | at_limit);
      walk_done = step & (at_limit | (qualifies & (probe >= {1'b0, bounds.high})));
      hash_pop  = walk_done;

      word.hash_value  = head.hash;
      word.probe_index = qualifies ? probe : '0;
      word.probe_valid = qualifies;
      word.probe_last  = walk_done;

      mask_in = mask_ff;
      if (walk_done) begin
         mask_in = '0;
      end else if (step) begin
         mask_in = {mask_ff[15:0], 1'b1};
      end

      oq_pop      = rsp_pop & (oq_count_ff != 2'd0);
      oq_wr_in    = oq_wr_ff ^ emit;
      oq_rd_in    = oq_rd_ff ^ oq_pop;
      oq_count_in = oq_count_ff;
      if (emit & ~oq_pop) begin
         oq_count_in = oq_count_ff + 2'd1;
      end else if (oq_pop & ~emit) begin
         oq_count_in = oq_count_ff - 2'd1;
      end

      rsp_empty = (oq_count_ff == 2'd0);
      rsp_data  = oq_mem_ff[oq_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_mem_ff[oq_wr_ff] <= word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= '0;
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= '0;
      end else begin
         mask_ff     <= mask_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   `THPG_ASSERT_SAME(a_mask_shape, clock, reset, 1'b1, (mask_ff & (mask_ff + 17'd1)) == 17'd0, "mask is not of the form 2**n - 1")
   `THPG_ASSERT_NEXT(a_walk_restart, clock, reset, walk_done, mask_ff == 17'd0, "mask not cleared after the final word of a key")
   `THPG_ASSERT_SAME(a_oq_bound, clock, reset, 1'b1, oq_count_ff != 2'd3, "output queue count out of range")

endmodule

FILE: rtl/core/table_hash_probe_generator_top.sv
// Channel  Direction  Handshake              Payload
// req      in         req_push / req_full    key_byte, key_last
// rsp      out        rsp_pop / rsp_empty    hash_value, probe_index, probe_valid, probe_last
// csr      in         csr_valid / csr_ready  csr_index, csr_data (17-bit bound)
//
// The two table lookups and adds of the front end run in the cycle that a key byte is taken,
// so bytes may follow each other on every clock while req_full is low.
// After the last byte the back end walks 1 to 18 masks per key, one per cycle while its
// two-word output queue has room, and queues every qualifying probe, or one invalid marker.
// A two-entry hash queue lets the front end hash the next keys while a walk is running;
// req_full rises only while that queue holds two keys.
// Synchronous reset clears the hash state, both queues and restores both bounds.
// csr_ready is always high.
module table_hash_probe_generator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  thpg_pkg::req_type  req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output thpg_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);
   import thpg_pkg::*;

   logic [16:0]   low_bound_ff, low_bound_in;
   logic [16:0]   high_bound_ff, high_bound_in;
   logic          req_accept, csr_write, hash_pop;
   bounds_type    bounds;
   hash_push_type hash_push;
   hash_head_type hash_head;

   always_comb begin
      csr_ready     = 1'b1;
      csr_write     = csr_valid & csr_ready;
      low_bound_in  = low_bound_ff;
      high_bound_in = high_bound_ff;
      if (csr_write && csr_index == CSR_LOW_BOUND) begin
         low_bound_in = csr_data;
      end
      if (csr_write && csr_index == CSR_HIGH_BOUND) begin
         high_bound_in = csr_data;
      end
      bounds.low  = low_bound_ff;
      bounds.high = high_bound_ff;
      req_accept  = req_push & ~req_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= LOW_BOUND_RESET;
         high_bound_ff <= HIGH_BOUND_RESET;
      end else begin
         low_bound_ff  <= low_bound_in;
         high_bound_ff <= high_bound_in;
      end
   end

   thpg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .hash_out (hash_push)
   );

   thpg_hash_queue u_hash_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (hash_push),
      .full    (req_full),
      .pop     (hash_pop),
      .head    (hash_head)
   );

   thpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (hash_head),
      .bounds    (bounds),
      .hash_pop  (hash_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
